// ----- sv/bitmap_object_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Bitmap object allocator assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BITMAP_OBJECT_ALLOCATOR_MACROS_SVH
`define BITMAP_OBJECT_ALLOCATOR_MACROS_SVH
`ifndef SYNTH
`define BOA_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
`define BOA_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BOA_ASSERT_IMPL(label, ck, rn, ante, cons, msg)
`define BOA_ASSERT_NEXT(label, ck, rn, ante, cons, msg)
`endif
`endif

// ----- sv/boa_pkg.sv -----
// ----------------------------------------------------------------------------
// Bitmap object allocator package
// Sizes, codes, payload types and helpers shared by the allocator files.
// ----------------------------------------------------------------------------
package boa_pkg;

    localparam int MAX_OBJECTS = 1024;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = MAX_OBJECTS / WORD_BITS;

    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int MAP_ADDR_W  = $clog2(MAP_WORDS);
    localparam int INDEX_W     = $clog2(MAX_OBJECTS);
    localparam int COUNT_W     = $clog2(MAX_OBJECTS + 1);
    localparam int WORDS_W     = $clog2(MAP_WORDS + 1);

    localparam int ADDR_W      = 48;
    localparam int SIZE_W      = 17;
    localparam int OBJ_CNT_W   = 11;
    localparam int LEN_W       = 17;
    localparam int HINT_W      = 6;
    localparam int PROD_W      = SIZE_W + INDEX_W;

    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_COUNT = 2'd2;

    localparam logic [ADDR_W-1:0]    BASE_RESET  = '0;
    localparam logic [SIZE_W-1:0]    SIZE_RESET  = 17'd2048;
    localparam logic [OBJ_CNT_W-1:0] COUNT_RESET = 11'd1024;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    typedef enum logic [2:0] {
        STAT_OK              = 3'd0,
        STAT_BAD_INDEX       = 3'd1,
        STAT_DOUBLE_FREE     = 3'd2,
        STAT_TOO_LARGE       = 3'd3,
        STAT_POOL_EMPTY      = 3'd4,
        STAT_NONE_AFTER_HINT = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_FREE_CHK,
        S_MUL,
        S_ADD,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic               func;
        logic [LEN_W-1:0]   request_length;
        logic [HINT_W-1:0]  start_hint;
        logic [INDEX_W-1:0] free_index;
    } in_item_t;

    typedef struct packed {
        status_t            status;
        logic [INDEX_W-1:0] alloc_index;
        logic [ADDR_W-1:0]  alloc_address;
        logic [HINT_W-1:0]  next_hint;
    } out_item_t;

    typedef struct packed {
        logic                  rd_en;
        logic [MAP_ADDR_W-1:0] rd_addr;
        logic                  wr_en;
        logic [MAP_ADDR_W-1:0] wr_addr;
        logic [WORD_BITS-1:0]  wr_data;
    } map_req_t;

    function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
        logic [BIT_IDX_W-1:0] pos;
        pos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (w[b])
            begin
                pos = BIT_IDX_W'(b);
            end
        end
        return pos;
    endfunction

endpackage

// ----- sv/boa_if.sv -----
// ----------------------------------------------------------------------------
// Bitmap object allocator channels
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface boa_in_if;
    logic             valid;
    logic             ready;
    boa_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface boa_out_if;
    logic              valid;
    logic              ready;
    boa_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/boa_map_mem.sv -----
// ----------------------------------------------------------------------------
// Bitmap object allocator free map memory
// One read and one write port, registered read, per-word valid bits so that
// unwritten words read as zero after reset.
// ----------------------------------------------------------------------------
module boa_map_mem
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  boa_pkg::map_req_t               req,
    output logic [boa_pkg::WORD_BITS-1:0]   rd_data
);

    logic [boa_pkg::WORD_BITS-1:0] mem [boa_pkg::MAP_WORDS];
    logic [boa_pkg::MAP_WORDS-1:0] valid_reg;
    logic [boa_pkg::WORD_BITS-1:0] rd_data_reg;
    logic                          rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

// ----- sv/boa_addr_unit.sv -----
// ----------------------------------------------------------------------------
// Bitmap object allocator address unit
// Two-stage base + size * index, wrapping at the address width.
// ----------------------------------------------------------------------------
module boa_addr_unit
(
    input  logic                            clk,
    input  logic [boa_pkg::ADDR_W-1:0]      base,
    input  logic [boa_pkg::SIZE_W-1:0]      size,
    input  logic [boa_pkg::INDEX_W-1:0]     index,
    output logic [boa_pkg::ADDR_W-1:0]      addr
);

    logic [boa_pkg::PROD_W-1:0] prod_reg;
    logic [boa_pkg::ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= boa_pkg::PROD_W'(size) * boa_pkg::PROD_W'(index);
        addr_reg <= base + boa_pkg::ADDR_W'(prod_reg);
    end

    assign addr = addr_reg;

endmodule

// ----- sv/boa_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bitmap object allocator controller
// Config registers, free count, scan sequencer and result register.
// ----------------------------------------------------------------------------
`include "bitmap_object_allocator_macros.svh"

module boa_ctrl
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [boa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [boa_pkg::CFG_DATA_W-1:0]     cfg_data,
    boa_in_if.sink                             req,
    boa_out_if.source                          rsp,
    output boa_pkg::map_req_t                  map_req,
    input  logic [boa_pkg::WORD_BITS-1:0]      rd_data,
    output logic [boa_pkg::ADDR_W-1:0]         base,
    output logic [boa_pkg::SIZE_W-1:0]         size,
    output logic [boa_pkg::INDEX_W-1:0]        index,
    input  logic [boa_pkg::ADDR_W-1:0]         addr
);

    boa_pkg::state_t                    state_reg, state_next;
    boa_pkg::in_item_t                  item_reg, item_next;
    boa_pkg::status_t                   status_reg, status_next;
    logic [boa_pkg::INDEX_W-1:0]        index_reg, index_next;
    logic [boa_pkg::HINT_W-1:0]         hint_reg, hint_next;
    logic [boa_pkg::HINT_W-1:0]         word_reg, word_next;
    logic [boa_pkg::COUNT_W-1:0]        free_count_reg, free_count_next;
    logic [boa_pkg::ADDR_W-1:0]         base_reg;
    logic [boa_pkg::SIZE_W-1:0]         size_reg;
    logic [boa_pkg::OBJ_CNT_W-1:0]      count_reg;
    logic                               out_valid_reg, out_valid_next;
    boa_pkg::out_item_t                 out_data_reg, out_data_next;

    logic [boa_pkg::OBJ_CNT_W-1:0]      valid_objs;
    logic [boa_pkg::OBJ_CNT_W-1:0]      round_up;
    logic [boa_pkg::WORDS_W-1:0]        words;
    logic [boa_pkg::HINT_W-1:0]         word_inc;
    logic                               bad_index;
    logic                               too_large;
    logic                               pool_empty;
    logic                               hint_past;
    logic                               word_hit;
    logic                               scan_end;
    logic                               bit_set;
    logic                               out_load;

    // derived pool geometry
    assign valid_objs = (count_reg > boa_pkg::OBJ_CNT_W'(boa_pkg::MAX_OBJECTS))
                      ? boa_pkg::OBJ_CNT_W'(boa_pkg::MAX_OBJECTS) : count_reg;
    assign round_up   = valid_objs + boa_pkg::OBJ_CNT_W'(boa_pkg::WORD_BITS - 1);
    assign words      = boa_pkg::WORDS_W'(round_up >> boa_pkg::BIT_IDX_W);

    assign bad_index  = boa_pkg::OBJ_CNT_W'(item_reg.free_index) >= valid_objs;
    assign too_large  = item_reg.request_length > size_reg;
    assign pool_empty = (free_count_reg == '0);
    assign hint_past  = item_reg.start_hint >= boa_pkg::HINT_W'(words);
    assign word_hit   = (rd_data != '0);
    assign word_inc   = word_reg + boa_pkg::HINT_W'(1);
    assign scan_end   = word_inc >= boa_pkg::HINT_W'(words);
    assign bit_set    = rd_data[item_reg.free_index[boa_pkg::BIT_IDX_W-1:0]];
    assign out_load   = (state_reg == boa_pkg::S_RESULT) && (!out_valid_reg || rsp.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            boa_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = boa_pkg::S_DECIDE;
                end
            end
            boa_pkg::S_DECIDE:
            begin
                if (item_reg.func == boa_pkg::FUNC_FREE)
                begin
                    state_next = bad_index ? boa_pkg::S_RESULT : boa_pkg::S_FREE_CHK;
                end
                else if (too_large || pool_empty || hint_past)
                begin
                    state_next = boa_pkg::S_RESULT;
                end
                else
                begin
                    state_next = boa_pkg::S_SCAN;
                end
            end
            boa_pkg::S_SCAN:
            begin
                if (word_hit)
                begin
                    state_next = boa_pkg::S_MUL;
                end
                else if (scan_end)
                begin
                    state_next = boa_pkg::S_RESULT;
                end
            end
            boa_pkg::S_FREE_CHK: state_next = boa_pkg::S_RESULT;
            boa_pkg::S_MUL:      state_next = boa_pkg::S_ADD;
            boa_pkg::S_ADD:      state_next = boa_pkg::S_RESULT;
            boa_pkg::S_RESULT:
            begin
                if (out_load)
                begin
                    state_next = boa_pkg::S_IDLE;
                end
            end
            default:             state_next = boa_pkg::S_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item_next        = item_reg;
        status_next      = status_reg;
        index_next       = index_reg;
        hint_next        = hint_reg;
        word_next        = word_reg;
        free_count_next  = free_count_reg;
        out_data_next    = out_data_reg;
        out_valid_next   = out_valid_reg && !rsp.ready;
        map_req.rd_en    = 1'b0;
        map_req.rd_addr  = word_reg[boa_pkg::MAP_ADDR_W-1:0];
        map_req.wr_en    = 1'b0;
        map_req.wr_addr  = word_reg[boa_pkg::MAP_ADDR_W-1:0];
        map_req.wr_data  = rd_data;
        req.ready        = 1'b0;

        unique case (state_reg)
            boa_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    item_next = req.data;
                end
            end
            boa_pkg::S_DECIDE:
            begin
                index_next = '0;
                if (item_reg.func == boa_pkg::FUNC_FREE)
                begin
                    hint_next = '0;
                    if (bad_index)
                    begin
                        status_next = boa_pkg::STAT_BAD_INDEX;
                    end
                    else
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr =
                            item_reg.free_index[boa_pkg::INDEX_W-1:boa_pkg::BIT_IDX_W];
                        word_next       = boa_pkg::HINT_W'(
                            item_reg.free_index[boa_pkg::INDEX_W-1:boa_pkg::BIT_IDX_W]);
                    end
                end
                else
                begin
                    hint_next = item_reg.start_hint;
                    if (too_large)
                    begin
                        status_next = boa_pkg::STAT_TOO_LARGE;
                    end
                    else if (pool_empty)
                    begin
                        status_next = boa_pkg::STAT_POOL_EMPTY;
                    end
                    else if (hint_past)
                    begin
                        status_next = boa_pkg::STAT_NONE_AFTER_HINT;
                    end
                    else
                    begin
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = item_reg.start_hint[boa_pkg::MAP_ADDR_W-1:0];
                        word_next       = item_reg.start_hint;
                    end
                end
            end
            boa_pkg::S_SCAN:
            begin
                if (word_hit)
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_data = rd_data & (rd_data - boa_pkg::WORD_BITS'(1));
                    free_count_next = free_count_reg - boa_pkg::COUNT_W'(1);
                    index_next      = {word_reg[boa_pkg::MAP_ADDR_W-1:0],
                                       boa_pkg::lowest_set(rd_data)};
                    hint_next       = word_reg;
                    status_next     = boa_pkg::STAT_OK;
                end
                else if (scan_end)
                begin
                    hint_next   = boa_pkg::HINT_W'(words);
                    status_next = boa_pkg::STAT_NONE_AFTER_HINT;
                end
                else
                begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = word_inc[boa_pkg::MAP_ADDR_W-1:0];
                    word_next       = word_inc;
                end
            end
            boa_pkg::S_FREE_CHK:
            begin
                if (bit_set)
                begin
                    status_next = boa_pkg::STAT_DOUBLE_FREE;
                end
                else
                begin
                    map_req.wr_en   = 1'b1;
                    map_req.wr_data = rd_data | (boa_pkg::WORD_BITS'(1)
                                      << item_reg.free_index[boa_pkg::BIT_IDX_W-1:0]);
                    free_count_next = free_count_reg + boa_pkg::COUNT_W'(1);
                    status_next     = boa_pkg::STAT_OK;
                end
            end
            boa_pkg::S_MUL:
            begin
            end
            boa_pkg::S_ADD:
            begin
            end
            boa_pkg::S_RESULT:
            begin
                if (out_load)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.status       = status_reg;
                    out_data_next.alloc_index  = index_reg;
                    out_data_next.next_hint    = hint_reg;
                    out_data_next.alloc_address =
                        (status_reg == boa_pkg::STAT_OK && item_reg.func == boa_pkg::FUNC_ALLOC)
                        ? addr : '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= boa_pkg::S_IDLE;
            free_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            base_reg       <= boa_pkg::BASE_RESET;
            size_reg       <= boa_pkg::SIZE_RESET;
            count_reg      <= boa_pkg::COUNT_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            free_count_reg <= free_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    boa_pkg::CFG_BASE_ADDRESS: base_reg  <= cfg_data[boa_pkg::ADDR_W-1:0];
                    boa_pkg::CFG_OBJECT_SIZE:  size_reg  <= cfg_data[boa_pkg::SIZE_W-1:0];
                    boa_pkg::CFG_OBJECT_COUNT: count_reg <= cfg_data[boa_pkg::OBJ_CNT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        status_reg   <= status_next;
        index_reg    <= index_next;
        hint_reg     <= hint_next;
        word_reg     <= word_next;
        out_data_reg <= out_data_next;
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign base      = base_reg;
    assign size      = size_reg;
    assign index     = index_reg;

    `BOA_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1,
        free_count_reg <= boa_pkg::COUNT_W'(boa_pkg::MAX_OBJECTS), "free count over pool size")
    `BOA_ASSERT_IMPL(a_write_state, clk, rst_n, map_req.wr_en,
        state_reg == boa_pkg::S_SCAN || state_reg == boa_pkg::S_FREE_CHK, "map write out of place")
    `BOA_ASSERT_NEXT(a_hit_to_mul, clk, rst_n, state_reg == boa_pkg::S_SCAN && word_hit,
        state_reg == boa_pkg::S_MUL && status_reg == boa_pkg::STAT_OK, "scan hit not taken")

endmodule

// ----- sv/bitmap_object_allocator.sv -----
// ----------------------------------------------------------------------------
// Bitmap object allocator
// First-fit allocator of fixed-size objects over a bitmap of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one allocate or free request per transfer; rsp returns exactly
//   one result per request, in order. Both are valid/ready channels.
//   cfg_we/cfg_index/cfg_data write base address, object size and object
//   count; write only while no request is in flight.
//   A free reads its map word, then checks the bit and writes it back; an
//   allocate scans from start_hint over n bitmap words (n <= 32, one map
//   read per cycle) and on a hit forms base + size * index in the product
//   and address registers of the address unit. A free with an index out of
//   range, a scan that finds none and a request rejected before the scan go
//   straight to the result. One request is in process at a time; the next
//   is taken in the cycle after the prior result enters the output register.
//   Reset: every object is in use, free count zero, registers at base 0,
//   size 2048, count 1024; the pool is filled by free requests.
//   A stalled rsp holds its result; one finished result may wait there while
//   the next request is processed.
// ----------------------------------------------------------------------------
module bitmap_object_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [boa_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [boa_pkg::CFG_DATA_W-1:0]  cfg_data,
    boa_in_if.sink                          req,
    boa_out_if.source                       rsp
);

    boa_pkg::map_req_t                  map_req;
    logic [boa_pkg::WORD_BITS-1:0]      rd_data;
    logic [boa_pkg::ADDR_W-1:0]         base;
    logic [boa_pkg::SIZE_W-1:0]         size;
    logic [boa_pkg::INDEX_W-1:0]        index;
    logic [boa_pkg::ADDR_W-1:0]         addr;

    boa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .rsp       (rsp),
        .map_req   (map_req),
        .rd_data   (rd_data),
        .base      (base),
        .size      (size),
        .index     (index),
        .addr      (addr)
    );

    boa_map_mem u_map
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (map_req),
        .rd_data (rd_data)
    );

    boa_addr_unit u_addr
    (
        .clk   (clk),
        .base  (base),
        .size  (size),
        .index (index),
        .addr  (addr)
    );

endmodule
